/* design/pfwp_pkg.sv */
// shared constants and types for the page fetch window planner
package pfwp_pkg;

  // field widths
  localparam int PAGE_W = 24;
  localparam int CNT_W  = 25;
  localparam int SZ_W   = 32;
  localparam int LOG_W  = 48;
  localparam int PROD_W = 56;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 48;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_PLAN_VALID        = 3'd0;
  localparam logic [IDX_W-1:0] REG_TOTAL_PAGES       = 3'd1;
  localparam logic [IDX_W-1:0] REG_PAYLOAD_SIZE      = 3'd2;
  localparam logic [IDX_W-1:0] REG_LOGICAL_SIZE      = 3'd3;
  localparam logic [IDX_W-1:0] REG_PREFIX_SIZE       = 3'd4;
  localparam logic [IDX_W-1:0] REG_SUFFIX_SIZE       = 3'd5;
  localparam logic [IDX_W-1:0] REG_FRAME_PREFIX_SIZE = 3'd6;
  localparam logic [IDX_W-1:0] REG_FRAME_SIZE        = 3'd7;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;
  localparam logic [QCNT_W-1:0] QFULL = 3'd4;

  typedef struct packed {
    logic              plan_valid;
    logic [CNT_W-1:0]  total_pages;
    logic [SZ_W-1:0]   payload_size;
    logic [LOG_W-1:0]  logical_size;
    logic [SZ_W-1:0]   prefix_size;
    logic [SZ_W-1:0]   suffix_size;
    logic [SZ_W-1:0]   frame_prefix_size;
    logic [SZ_W-1:0]   frame_size;
  } cfg_t;

  // classified page as handed from front to back
  typedef struct packed {
    logic             ok_in;
    logic             has_prev;
    logic [LOG_W-1:0] core;
    logic [LOG_W-1:0] pcore;
  } q_t;

endpackage

/* design/page_fetch_window_planner.sv */
// top level of the page fetch window planner: configuration registers, front, queue, back
//
// For each page index this block returns the clipped core length, the fetch window
// (logical start, length, landing position in the frame) and what part of it can be
// copied from the previous page's frame, with the tail still to be read. One page is
// accepted per clock and one result delivered per clock, sustained, while the result
// side keeps up. A page passes two front stages (the 24 x 32 bit core start
// multiplier, then the logical end check), the four-entry queue, and seven back
// stages, each holding a step of the window and overlap arithmetic, the last being
// the output register. A stall on the result side fills the back stages and the
// queue before the input side is stalled. Configuration is to be written only when
// no page is in flight; the block itself does not enforce it. The configuration
// registers, stage valid flags and queue pointers reset to zero.
module page_fetch_window_planner (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [pfwp_pkg::IDX_W-1:0]    cfg_index,
  input  logic [pfwp_pkg::DATA_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pfwp_pkg::PAGE_W-1:0]   page_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfwp_pkg::SZ_W-1:0]     core_bytes,
  output logic                          window_ok,
  output logic [pfwp_pkg::LOG_W-1:0]    window_offset,
  output logic [pfwp_pkg::SZ_W-1:0]     window_bytes,
  output logic [pfwp_pkg::SZ_W-1:0]     window_frame_offset,
  output logic                          reuse_ok,
  output logic [pfwp_pkg::SZ_W-1:0]     reuse_frame_offset,
  output logic [pfwp_pkg::SZ_W-1:0]     reuse_bytes,
  output logic [pfwp_pkg::LOG_W-1:0]    tail_offset,
  output logic [pfwp_pkg::SZ_W-1:0]     tail_frame_offset,
  output logic [pfwp_pkg::SZ_W-1:0]     tail_bytes
);

  pfwp_pkg::cfg_t cfg;
  logic           push_valid;
  pfwp_pkg::q_t   push_data;
  logic           q_full;
  logic           head_valid;
  pfwp_pkg::q_t   head;
  logic           pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        pfwp_pkg::REG_PLAN_VALID:        cfg.plan_valid        <= cfg_data[0];
        pfwp_pkg::REG_TOTAL_PAGES:       cfg.total_pages       <= cfg_data[24:0];
        pfwp_pkg::REG_PAYLOAD_SIZE:      cfg.payload_size      <= cfg_data[31:0];
        pfwp_pkg::REG_LOGICAL_SIZE:      cfg.logical_size      <= cfg_data[47:0];
        pfwp_pkg::REG_PREFIX_SIZE:       cfg.prefix_size       <= cfg_data[31:0];
        pfwp_pkg::REG_SUFFIX_SIZE:       cfg.suffix_size       <= cfg_data[31:0];
        pfwp_pkg::REG_FRAME_PREFIX_SIZE: cfg.frame_prefix_size <= cfg_data[31:0];
        pfwp_pkg::REG_FRAME_SIZE:        cfg.frame_size        <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // page intake and classification
  pfwp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .page_index (page_index),
    .push_valid (push_valid),
    .q_full     (q_full),
    .push_data  (push_data)
  );

  // decoupling queue
  pfwp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_full     (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // window and reuse planning
  pfwp_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .cfg                 (cfg),
    .head_valid          (head_valid),
    .head                (head),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .core_bytes          (core_bytes),
    .window_ok           (window_ok),
    .window_offset       (window_offset),
    .window_bytes        (window_bytes),
    .window_frame_offset (window_frame_offset),
    .reuse_ok            (reuse_ok),
    .reuse_frame_offset  (reuse_frame_offset),
    .reuse_bytes         (reuse_bytes),
    .tail_offset         (tail_offset),
    .tail_frame_offset   (tail_frame_offset),
    .tail_bytes          (tail_bytes)
  );

endmodule

/* design/pfwp_front.sv */
// front end: accepts page indexes, forms the core start and classifies the page
module pfwp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  pfwp_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pfwp_pkg::PAGE_W-1:0]   page_index,
  output logic                          push_valid,
  input  logic                          q_full,
  output pfwp_pkg::q_t                  push_data
);

  logic                          v1;
  logic                          v2;
  logic [pfwp_pkg::PROD_W-1:0]   prod1;
  logic                          pok1;
  logic                          nz1;
  pfwp_pkg::q_t                  q2;
  logic                          f1_ready;
  logic                          f2_ready;

  // stage advance
  always_comb begin
    f2_ready = !v2 || !q_full;
    f1_ready = !v1 || f2_ready;
  end

  assign in_stall   = !f1_ready;
  assign push_valid = v2;
  assign push_data  = q2;

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (f1_ready) begin
        v1 <= in_valid;
      end
      if (f2_ready) begin
        v2 <= v1;
      end
    end
  end

  // stage one: core start product and page range check
  always_ff @(posedge clk) begin
    if (f1_ready) begin
      prod1 <= {32'b0, page_index} * {24'b0, cfg.payload_size};
      pok1  <= cfg.plan_valid && ({1'b0, page_index} < cfg.total_pages);
      nz1   <= page_index != '0;
    end
  end

  // stage two: core start against logical end, previous page core start
  always_ff @(posedge clk) begin
    if (f2_ready) begin
      q2.ok_in    <= pok1 && (prod1 < {8'b0, cfg.logical_size});
      q2.has_prev <= nz1;
      q2.core     <= prod1[pfwp_pkg::LOG_W-1:0];
      q2.pcore    <= prod1[pfwp_pkg::LOG_W-1:0] - {16'b0, cfg.payload_size};
    end
  end

endmodule

/* design/pfwp_queue.sv */
// short queue of classified pages between front and back
module pfwp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  pfwp_pkg::q_t  push_data,
  output logic          q_full,
  output logic          head_valid,
  output pfwp_pkg::q_t  head,
  input  logic          pop
);

  pfwp_pkg::q_t                  mem [pfwp_pkg::QDEPTH];
  logic [pfwp_pkg::QPTR_W-1:0]   wr_ptr;
  logic [pfwp_pkg::QPTR_W-1:0]   rd_ptr;
  logic [pfwp_pkg::QCNT_W-1:0]   count;
  logic                          push;

  assign q_full     = count == pfwp_pkg::QFULL;
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign push       = push_valid && !q_full;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a lone push");
`endif

endmodule

/* design/pfwp_back.sv */
// back end: window planning for the page and the page before, overlap and tail
module pfwp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  pfwp_pkg::cfg_t                cfg,
  input  logic                          head_valid,
  input  pfwp_pkg::q_t                  head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfwp_pkg::SZ_W-1:0]     core_bytes,
  output logic                          window_ok,
  output logic [pfwp_pkg::LOG_W-1:0]    window_offset,
  output logic [pfwp_pkg::SZ_W-1:0]     window_bytes,
  output logic [pfwp_pkg::SZ_W-1:0]     window_frame_offset,
  output logic                          reuse_ok,
  output logic [pfwp_pkg::SZ_W-1:0]     reuse_frame_offset,
  output logic [pfwp_pkg::SZ_W-1:0]     reuse_bytes,
  output logic [pfwp_pkg::LOG_W-1:0]    tail_offset,
  output logic [pfwp_pkg::SZ_W-1:0]     tail_frame_offset,
  output logic [pfwp_pkg::SZ_W-1:0]     tail_bytes
);

  // one window under construction
  typedef struct packed {
    logic        ok_in;
    logic [47:0] core;
    logic [31:0] pre;
    logic [47:0] cend;
    logic [47:0] start;
    logic [47:0] avail;
    logic        pre_bad;
    logic [31:0] tgt;
    logic [47:0] wend;
    logic        tgt_bad;
    logic [31:0] fs_rem;
    logic        ok;
    logic [31:0] len;
  } win_t;

  // one page in flight
  typedef struct packed {
    win_t        cur;
    win_t        prv;
    logic        has_prev;
    logic [31:0] core_bytes;
    logic        overlap;
    logic [47:0] rend;
    logic [47:0] dstart;
    logic [47:0] n;
    logic [48:0] src;
    logic [47:0] rb;
  } back_t;

  // prefix clip and core end clip
  function automatic win_t win_s1(input win_t wi, input pfwp_pkg::cfg_t c);
    win_t        w;
    logic [48:0] sum;
    w      = wi;
    w.pre  = (w.core < {16'b0, c.prefix_size}) ? w.core[31:0] : c.prefix_size;
    sum    = {1'b0, w.core} + {17'b0, c.payload_size};
    w.cend = (sum > {1'b0, c.logical_size}) ? c.logical_size : sum[47:0];
    return w;
  endfunction

  // window start, room after the core, frame target
  function automatic win_t win_s2(input win_t wi, input pfwp_pkg::cfg_t c);
    win_t        w;
    logic [32:0] dif;
    w         = wi;
    w.start   = w.core - {16'b0, w.pre};
    w.avail   = c.logical_size - w.cend;
    dif       = {1'b0, c.frame_prefix_size} - {1'b0, w.pre};
    w.pre_bad = dif[32];
    w.tgt     = dif[31:0];
    return w;
  endfunction

  // suffix clip and window end, frame room after the target
  function automatic win_t win_s3(input win_t wi, input pfwp_pkg::cfg_t c);
    win_t        w;
    logic [47:0] suf;
    w         = wi;
    suf       = ({16'b0, c.suffix_size} < w.avail) ? {16'b0, c.suffix_size} : w.avail;
    w.wend    = w.cend + suf;
    w.tgt_bad = w.tgt > c.frame_size;
    w.fs_rem  = c.frame_size - w.tgt;
    return w;
  endfunction

  // window length and fit in the frame
  function automatic win_t win_s4(input win_t wi);
    win_t        w;
    logic [48:0] dif;
    w     = wi;
    dif   = {1'b0, w.wend} - {1'b0, w.start};
    w.ok  = w.ok_in && !w.pre_bad && !w.tgt_bad && (w.wend > w.start) &&
            (dif <= {17'b0, w.fs_rem});
    w.len = dif[31:0];
    return w;
  endfunction

  function automatic back_t stg1(input pfwp_pkg::q_t h, input pfwp_pkg::cfg_t c);
    back_t       b;
    logic [47:0] rest;
    b              = '0;
    b.has_prev     = h.has_prev;
    b.cur.ok_in    = h.ok_in;
    b.cur.core     = h.core;
    b.prv.ok_in    = h.ok_in && h.has_prev;
    b.prv.core     = h.pcore;
    rest           = c.logical_size - h.core;
    if (!h.ok_in) begin
      b.core_bytes = '0;
    end else if ({16'b0, c.payload_size} < rest) begin
      b.core_bytes = c.payload_size;
    end else begin
      b.core_bytes = rest[31:0];
    end
    b.cur          = win_s1(b.cur, c);
    b.prv          = win_s1(b.prv, c);
    return b;
  endfunction

  // both windows through the start and target step
  function automatic back_t stg2(input back_t bi, input pfwp_pkg::cfg_t c);
    back_t b;
    b     = bi;
    b.cur = win_s2(bi.cur, c);
    b.prv = win_s2(bi.prv, c);
    return b;
  endfunction

  // both windows through the suffix step
  function automatic back_t stg3(input back_t bi, input pfwp_pkg::cfg_t c);
    back_t b;
    b     = bi;
    b.cur = win_s3(bi.cur, c);
    b.prv = win_s3(bi.prv, c);
    return b;
  endfunction

  // both windows through the fit step
  function automatic back_t stg4(input back_t bi);
    back_t b;
    b     = bi;
    b.cur = win_s4(bi.cur);
    b.prv = win_s4(bi.prv);
    return b;
  endfunction

  // overlap of the current window with the previous one
  function automatic back_t stg5(input back_t bi);
    back_t b;
    b         = bi;
    b.overlap = (b.cur.start >= b.prv.start) && (b.cur.start < b.prv.wend);
    b.rend    = (b.prv.wend < b.cur.wend) ? b.prv.wend : b.cur.wend;
    b.dstart  = b.cur.start - b.prv.start;
    return b;
  endfunction

  // copied length, source position in the prior frame, tail length
  function automatic back_t stg6(input back_t bi);
    back_t b;
    b     = bi;
    b.n   = b.rend - b.cur.start;
    b.src = {17'b0, b.prv.tgt} + {1'b0, b.dstart};
    b.rb  = b.cur.wend - b.rend;
    return b;
  endfunction

  back_t       s1;
  back_t       s2;
  back_t       s3;
  back_t       s4;
  back_t       s5;
  back_t       s6;
  logic [6:0]  v;
  logic [6:0]  rdy;
  logic [49:0] src_end;
  logic        src_fit;
  logic        reuse_ok_next;

  // ready chain back from the output register
  always_comb begin
    rdy[6] = !v[6] || !out_stall;
    rdy[5] = !v[5] || rdy[6];
    rdy[4] = !v[4] || rdy[5];
    rdy[3] = !v[3] || rdy[4];
    rdy[2] = !v[2] || rdy[3];
    rdy[1] = !v[1] || rdy[2];
    rdy[0] = !v[0] || rdy[1];
  end

  assign pop       = head_valid && rdy[0];
  assign out_valid = v[6];

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= head_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) v[4] <= v[3];
      if (rdy[5]) v[5] <= v[4];
      if (rdy[6]) v[6] <= v[5];
    end
  end

  // planning stages
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1 <= stg1(head, cfg);
    end
    if (rdy[1]) begin
      s2 <= stg2(s1, cfg);
    end
    if (rdy[2]) begin
      s3 <= stg3(s2, cfg);
    end
    if (rdy[3]) begin
      s4 <= stg4(s3);
    end
    if (rdy[4]) begin
      s5 <= stg5(s4);
    end
    if (rdy[5]) begin
      s6 <= stg6(s5);
    end
  end

  // the copy must end inside the prior frame; the tail always fits when the window does
  always_comb begin
    src_end       = {1'b0, s6.src} + {2'b0, s6.n};
    src_fit       = src_end <= {18'b0, cfg.frame_size};
    reuse_ok_next = s6.cur.ok && s6.has_prev && s6.prv.ok && s6.overlap && src_fit;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      core_bytes          <= s6.core_bytes;
      window_ok           <= s6.cur.ok;
      window_offset       <= s6.cur.ok ? s6.cur.start : '0;
      window_bytes        <= s6.cur.ok ? s6.cur.len : '0;
      window_frame_offset <= s6.cur.ok ? s6.cur.tgt : '0;
      reuse_ok            <= reuse_ok_next;
      reuse_frame_offset  <= reuse_ok_next ? s6.src[31:0] : '0;
      reuse_bytes         <= reuse_ok_next ? s6.n[31:0] : '0;
      tail_offset         <= reuse_ok_next ? s6.rend : '0;
      tail_frame_offset   <= reuse_ok_next ? (s6.cur.tgt + s6.n[31:0]) : '0;
      tail_bytes          <= reuse_ok_next ? s6.rb[31:0] : '0;
    end
  end

`ifndef SYNTHESIS
  a_reuse_splits_window: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reuse_ok) |->
      (window_ok && (window_bytes == reuse_bytes + tail_bytes)))
    else $error("copy and tail do not make up the window");

  a_no_window_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !window_ok) |->
      (window_bytes == '0 && window_offset == '0 && !reuse_ok))
    else $error("rejected window carries data");
`endif

endmodule

/* bench/fetch_plan_checker.sv */
`timescale 1ns / 100ps
// checker for the page fetch window planner: shadow registers, plan prediction, result compare
module fetch_plan_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [pfwp_pkg::IDX_W-1:0]    cfg_index,
  input  logic [pfwp_pkg::DATA_W-1:0]   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [pfwp_pkg::PAGE_W-1:0]   page_index,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [pfwp_pkg::SZ_W-1:0]     core_bytes,
  input  logic                          window_ok,
  input  logic [pfwp_pkg::LOG_W-1:0]    window_offset,
  input  logic [pfwp_pkg::SZ_W-1:0]     window_bytes,
  input  logic [pfwp_pkg::SZ_W-1:0]     window_frame_offset,
  input  logic                          reuse_ok,
  input  logic [pfwp_pkg::SZ_W-1:0]     reuse_frame_offset,
  input  logic [pfwp_pkg::SZ_W-1:0]     reuse_bytes,
  input  logic [pfwp_pkg::LOG_W-1:0]    tail_offset,
  input  logic [pfwp_pkg::SZ_W-1:0]     tail_frame_offset,
  input  logic [pfwp_pkg::SZ_W-1:0]     tail_bytes,
  output int                            fail_count,
  output int                            open_count,
  output int                            plans_checked,
  output int                            windows_seen,
  output int                            reuses_seen
);

  typedef struct {
    logic        ok;
    logic [63:0] offset;
    logic [63:0] bytes;
    logic [63:0] target;
  } fetch_win_t;

  typedef struct {
    logic [pfwp_pkg::PAGE_W-1:0] page;
    logic [pfwp_pkg::SZ_W-1:0]   core_bytes;
    logic                        window_ok;
    logic [pfwp_pkg::LOG_W-1:0]  window_offset;
    logic [pfwp_pkg::SZ_W-1:0]   window_bytes;
    logic [pfwp_pkg::SZ_W-1:0]   window_frame_offset;
    logic                        reuse_ok;
    logic [pfwp_pkg::SZ_W-1:0]   reuse_frame_offset;
    logic [pfwp_pkg::SZ_W-1:0]   reuse_bytes;
    logic [pfwp_pkg::LOG_W-1:0]  tail_offset;
    logic [pfwp_pkg::SZ_W-1:0]   tail_frame_offset;
    logic [pfwp_pkg::SZ_W-1:0]   tail_bytes;
  } page_plan_t;

  pfwp_pkg::cfg_t shadow;
  page_plan_t     plans_due[$];

  // core length of a page, clipped at the logical end
  function automatic logic [pfwp_pkg::SZ_W-1:0] clipped_core(input logic [63:0] pg);
    logic [63:0] core_at, rest;
    if (!shadow.plan_valid || pg >= 64'(shadow.total_pages)) return '0;
    core_at = pg * 64'(shadow.payload_size);
    if (core_at >= 64'(shadow.logical_size)) return '0;
    rest = 64'(shadow.logical_size) - core_at;
    return (64'(shadow.payload_size) < rest) ? shadow.payload_size :
           rest[pfwp_pkg::SZ_W-1:0];
  endfunction

  // fetch window of one page and where it lands in its frame
  function automatic fetch_win_t window_of(input logic [63:0] pg);
    fetch_win_t w;
    logic [63:0] core_at, pre, start, cend, avail, post, wend, land, fpre, fs, lsz;
    w = '{ok: 1'b0, offset: 64'd0, bytes: 64'd0, target: 64'd0};
    lsz = 64'(shadow.logical_size);
    fpre = 64'(shadow.frame_prefix_size);
    fs = 64'(shadow.frame_size);
    if (!shadow.plan_valid || pg >= 64'(shadow.total_pages)) return w;
    core_at = pg * 64'(shadow.payload_size);
    if (core_at >= lsz) return w;
    pre = (core_at < 64'(shadow.prefix_size)) ? core_at : 64'(shadow.prefix_size);
    start = core_at - pre;
    cend = core_at + 64'(shadow.payload_size);
    if (cend > lsz) cend = lsz;
    avail = lsz - cend;
    post = (64'(shadow.suffix_size) < avail) ? 64'(shadow.suffix_size) : avail;
    wend = cend + post;
    if (pre > fpre) return w;
    land = fpre - pre;
    if (wend <= start || land > fs || wend - start > fs - land) return w;
    w.ok = 1'b1;
    w.offset = start;
    w.bytes = wend - start;
    w.target = land;
    return w;
  endfunction

  // full plan of a page, including the overlap with the page before
  function automatic page_plan_t predict_plan(input logic [pfwp_pkg::PAGE_W-1:0] page);
    page_plan_t p;
    fetch_win_t cur, pri;
    logic [63:0] pg, fs, pend, cend, rend, n, src, rt, rb;
    pg = 64'(page);
    fs = 64'(shadow.frame_size);
    cur = window_of(pg);
    p = '{default: '0};
    p.page = page;
    p.core_bytes = clipped_core(pg);
    p.window_ok = cur.ok;
    p.window_offset = cur.offset[pfwp_pkg::LOG_W-1:0];
    p.window_bytes = cur.bytes[pfwp_pkg::SZ_W-1:0];
    p.window_frame_offset = cur.target[pfwp_pkg::SZ_W-1:0];
    if (cur.ok && pg != 64'd0) begin
      pri = window_of(pg - 64'd1);
      pend = pri.offset + pri.bytes;
      cend = cur.offset + cur.bytes;
      if (pri.ok && cur.offset >= pri.offset && cur.offset < pend && cend > cur.offset) begin
        rend = (pend < cend) ? pend : cend;
        n = rend - cur.offset;
        src = pri.target + (cur.offset - pri.offset);
        rt = cur.target + n;
        rb = cend - rend;
        // copy and tail must both fit their frames
        if (n != 64'd0 && src <= fs && n <= fs - src && cur.target <= fs &&
            n <= fs - cur.target && rt <= fs && rb <= fs - rt) begin
          p.reuse_ok = 1'b1;
          p.reuse_frame_offset = src[pfwp_pkg::SZ_W-1:0];
          p.reuse_bytes = n[pfwp_pkg::SZ_W-1:0];
          p.tail_offset = rend[pfwp_pkg::LOG_W-1:0];
          p.tail_frame_offset = rt[pfwp_pkg::SZ_W-1:0];
          p.tail_bytes = rb[pfwp_pkg::SZ_W-1:0];
        end
      end
    end
    return p;
  endfunction

  function automatic void check_field(input string name,
                                      input logic [pfwp_pkg::PAGE_W-1:0] page,
                                      input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      if (fail_count < 10)
        $display("%0t: page %0d %s expected %h got %h", $realtime, page, name, want, got);
      fail_count++;
    end
  endfunction

  // watch config writes, page transfers and result transfers
  always @(posedge clk) begin
    page_plan_t want;
    if (rst) begin
      shadow = '0;
      plans_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (plans_due.size() == 0) begin
          if (fail_count < 10) $display("%0t: result transfer with no page waiting", $realtime);
          fail_count++;
        end else begin
          want = plans_due.pop_front();
          check_field("core_bytes", want.page, 64'(want.core_bytes), 64'(core_bytes));
          check_field("window_ok", want.page, 64'(want.window_ok), 64'(window_ok));
          check_field("window_offset", want.page, 64'(want.window_offset),
                      64'(window_offset));
          check_field("window_bytes", want.page, 64'(want.window_bytes), 64'(window_bytes));
          check_field("window_frame_offset", want.page, 64'(want.window_frame_offset),
                      64'(window_frame_offset));
          check_field("reuse_ok", want.page, 64'(want.reuse_ok), 64'(reuse_ok));
          check_field("reuse_frame_offset", want.page, 64'(want.reuse_frame_offset),
                      64'(reuse_frame_offset));
          check_field("reuse_bytes", want.page, 64'(want.reuse_bytes), 64'(reuse_bytes));
          check_field("tail_offset", want.page, 64'(want.tail_offset), 64'(tail_offset));
          check_field("tail_frame_offset", want.page, 64'(want.tail_frame_offset),
                      64'(tail_frame_offset));
          check_field("tail_bytes", want.page, 64'(want.tail_bytes), 64'(tail_bytes));
          plans_checked++;
          if (want.window_ok) windows_seen++;
          if (want.reuse_ok) reuses_seen++;
        end
      end
      if (in_valid && !in_stall) plans_due.push_back(predict_plan(page_index));
      if (cfg_write) begin
        case (cfg_index)
          pfwp_pkg::REG_PLAN_VALID:
            shadow.plan_valid = cfg_data[0];
          pfwp_pkg::REG_TOTAL_PAGES:
            shadow.total_pages = cfg_data[pfwp_pkg::CNT_W-1:0];
          pfwp_pkg::REG_PAYLOAD_SIZE:
            shadow.payload_size = cfg_data[pfwp_pkg::SZ_W-1:0];
          pfwp_pkg::REG_LOGICAL_SIZE:
            shadow.logical_size = cfg_data[pfwp_pkg::LOG_W-1:0];
          pfwp_pkg::REG_PREFIX_SIZE:
            shadow.prefix_size = cfg_data[pfwp_pkg::SZ_W-1:0];
          pfwp_pkg::REG_SUFFIX_SIZE:
            shadow.suffix_size = cfg_data[pfwp_pkg::SZ_W-1:0];
          pfwp_pkg::REG_FRAME_PREFIX_SIZE:
            shadow.frame_prefix_size = cfg_data[pfwp_pkg::SZ_W-1:0];
          pfwp_pkg::REG_FRAME_SIZE:
            shadow.frame_size = cfg_data[pfwp_pkg::SZ_W-1:0];
          default: ;
        endcase
      end
    end
    open_count <= plans_due.size();
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// testbench top for the page fetch window planner: clock, reset, stimulus and verdict
module tb;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [pfwp_pkg::IDX_W-1:0]    cfg_index;
  logic [pfwp_pkg::DATA_W-1:0]   cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [pfwp_pkg::PAGE_W-1:0]   page_index;
  logic                          out_valid;
  logic                          out_stall;
  logic [pfwp_pkg::SZ_W-1:0]     core_bytes;
  logic                          window_ok;
  logic [pfwp_pkg::LOG_W-1:0]    window_offset;
  logic [pfwp_pkg::SZ_W-1:0]     window_bytes;
  logic [pfwp_pkg::SZ_W-1:0]     window_frame_offset;
  logic                          reuse_ok;
  logic [pfwp_pkg::SZ_W-1:0]     reuse_frame_offset;
  logic [pfwp_pkg::SZ_W-1:0]     reuse_bytes;
  logic [pfwp_pkg::LOG_W-1:0]    tail_offset;
  logic [pfwp_pkg::SZ_W-1:0]     tail_frame_offset;
  logic [pfwp_pkg::SZ_W-1:0]     tail_bytes;

  int fail_count, open_count, plans_checked, windows_seen, reuses_seen;
  int unsigned gap_pct, stall_pct, pages_sent, settings_used, random_goal;

  page_fetch_window_planner uut (.*);
  fetch_plan_checker plan_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin
    #8_000_000;
    $display("** page_fetch_window_planner: FAILED **");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] field_max(input int w);
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic logic [63:0] clip(input logic [63:0] v, input int w);
    return (v > field_max(w)) ? field_max(w) : v;
  endfunction

  function automatic logic [63:0] pick_edge(input int w);
    case ($urandom_range(0, 3))
      0: return 64'd0;
      1: return 64'd1;
      2: return field_max(w);
      default: return field_max(w) - 64'd1;
    endcase
  endfunction

  // result side stall, held for random stretches
  initial begin
    int unsigned hold;
    logic stall_now;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        stall_now = ($urandom_range(0, 99) < stall_pct);
        hold = stall_now ? pick_gap() : $urandom_range(1, 6);
        out_stall <= stall_now;
      end
      hold--;
    end
  end

  // one page transfer, then maybe an idle gap
  task automatic send_page(input logic [pfwp_pkg::PAGE_W-1:0] pg);
    in_valid <= 1'b1;
    page_index <= pg;
    do @(posedge clk); while (in_stall);
    pages_sent++;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // drop valid and wait until every page in flight has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // junk above the register width checks the masking
  task automatic write_reg(input logic [pfwp_pkg::IDX_W-1:0] idx, input logic [63:0] val,
                           input int w);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= pfwp_pkg::DATA_W'((rand64() & ~field_max(w)) | (val & field_max(w)));
    @(posedge clk);
  endtask

  task automatic program_plan(input logic [63:0] pv, tp, ps, ls, pre, suf, fp, fs);
    write_reg(pfwp_pkg::REG_PLAN_VALID, pv, 1);
    write_reg(pfwp_pkg::REG_TOTAL_PAGES, tp, pfwp_pkg::CNT_W);
    write_reg(pfwp_pkg::REG_PAYLOAD_SIZE, ps, pfwp_pkg::SZ_W);
    write_reg(pfwp_pkg::REG_LOGICAL_SIZE, ls, pfwp_pkg::LOG_W);
    write_reg(pfwp_pkg::REG_PREFIX_SIZE, pre, pfwp_pkg::SZ_W);
    write_reg(pfwp_pkg::REG_SUFFIX_SIZE, suf, pfwp_pkg::SZ_W);
    write_reg(pfwp_pkg::REG_FRAME_PREFIX_SIZE, fp, pfwp_pkg::SZ_W);
    write_reg(pfwp_pkg::REG_FRAME_SIZE, fs, pfwp_pkg::SZ_W);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 15;
      2: return 40;
      default: return 75;
    endcase
  endfunction

  // one random plan setting followed by a burst of pages
  task automatic random_phase(input int unsigned n);
    logic [63:0] pv, tp, ps, ls, pre, suf, fp, fs, hi, pg;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      // well-formed plan: windows mostly fit and neighbours overlap
      tp = $urandom_range(1, 48);
      r = $urandom_range(0, 99);
      ps = (r < 70) ? 64'($urandom_range(1, 4000)) :
           (r < 90) ? 64'($urandom_range(1, 1 << 20)) : 64'($urandom);
      pre = ($urandom_range(0, 3) == 0) ? 64'd0 :
            clip(rand64() % (2 * ps + 1), pfwp_pkg::SZ_W);
      suf = ($urandom_range(0, 3) == 0) ? 64'd0 :
            clip(rand64() % (2 * ps + 1), pfwp_pkg::SZ_W);
      fp = ($urandom_range(0, 6) == 0 && pre != 0) ? pre - 64'd1 :
           clip(pre + $urandom_range(0, 8), pfwp_pkg::SZ_W);
      fs = ($urandom_range(0, 4) == 0) ? fp + ps / 2 + $urandom_range(0, 16) :
           fp + ps + suf + $urandom_range(0, 16);
      fs = clip(fs, pfwp_pkg::SZ_W);
      ls = tp * ps - rand64() % (ps + 1);
      if ($urandom_range(0, 5) == 0) ls = ls + $urandom_range(0, 5000);
      ls = clip(ls, pfwp_pkg::LOG_W);
      pv = ($urandom_range(0, 19) != 0);
    end else if (r < 85) begin
      // raw noise over the full register widths
      pv = $urandom_range(0, 1);
      tp = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 64)) :
           rand64() & field_max(pfwp_pkg::CNT_W);
      ps = rand64() & field_max($urandom_range(1, pfwp_pkg::SZ_W));
      ls = rand64() & field_max(pfwp_pkg::LOG_W);
      pre = rand64() & field_max(pfwp_pkg::SZ_W);
      suf = rand64() & field_max(pfwp_pkg::SZ_W);
      fp = rand64() & field_max(pfwp_pkg::SZ_W);
      fs = rand64() & field_max(pfwp_pkg::SZ_W);
    end else begin
      pv = $urandom_range(0, 1);
      tp = pick_edge(pfwp_pkg::CNT_W);
      if (tp > 64'h100_0000) tp = 64'h100_0000;
      ps = pick_edge(pfwp_pkg::SZ_W);
      ls = pick_edge(pfwp_pkg::LOG_W);
      pre = pick_edge(pfwp_pkg::SZ_W);
      suf = pick_edge(pfwp_pkg::SZ_W);
      fp = pick_edge(pfwp_pkg::SZ_W);
      fs = pick_edge(pfwp_pkg::SZ_W);
    end
    program_plan(pv, tp, ps, ls, pre, suf, fp, fs);
    gap_pct = pick_pct();
    stall_pct = pick_pct();
    hi = (tp + 1 > field_max(pfwp_pkg::PAGE_W)) ? field_max(pfwp_pkg::PAGE_W) : tp + 1;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 75) pg = $urandom_range(0, hi[31:0]);
      else if (r < 85) pg = clip((tp > 3) ? tp - $urandom_range(0, 3) :
                                 64'($urandom_range(0, 3)), pfwp_pkg::PAGE_W);
      else pg = $urandom_range(0, 24'hFFFFFF);
      send_page(pg[pfwp_pkg::PAGE_W-1:0]);
    end
    settle();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    page_index <= '0;
    gap_pct = 30;
    stall_pct = 30;
    pages_sent = 0;
    settings_used = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // registers still at reset: plan not set up
    send_page('0);
    send_page('1);
    settle();

    // small plan: prefix clipped at zero, short last core, pages past the end
    program_plan(1, 20, 100, 1050, 30, 40, 30, 300);
    send_page(0);
    send_page(1);
    send_page(2);
    send_page(9);
    send_page(10);
    send_page(11);
    send_page(19);
    send_page(20);
    send_page('1);
    settle();

    // prefix taken exceeds the reserved frame prefix
    program_plan(1, 20, 100, 1050, 30, 40, 10, 300);
    send_page(0);
    send_page(1);
    settle();

    // frame exactly big enough, then one byte short
    program_plan(1, 20, 100, 1050, 30, 40, 30, 170);
    send_page(1);
    send_page(2);
    settle();
    program_plan(1, 20, 100, 1050, 30, 40, 30, 169);
    send_page(1);
    settle();

    // every register at its top value, but total pages set to cover every page index
    program_plan(1, 64'h100_0000, 64'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF,
                 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF);
    send_page(0);
    send_page(1);
    send_page('1);
    settle();

    // empty payload: every page shares the same window
    program_plan(1, 8, 0, 5, 0, 2, 0, 16);
    send_page(0);
    send_page(3);
    settle();

    random_goal = pages_sent + 1300;
    while (pages_sent < random_goal) random_phase($urandom_range(30, 70));

    $display("%0d pages sent over %0d plan settings, %0d results checked", pages_sent,
             settings_used, plans_checked);
    $display("%0d results had a fetch window, %0d copied bytes from the prior frame",
             windows_seen, reuses_seen);
    if (fail_count == 0) $display("** page_fetch_window_planner: PASSED **");
    else $display("** page_fetch_window_planner: FAILED **");
    $finish;
  end

endmodule

/* files.f */
design/pfwp_pkg.sv
design/pfwp_front.sv
design/pfwp_queue.sv
design/pfwp_back.sv
design/page_fetch_window_planner.sv
bench/fetch_plan_checker.sv
bench/tb.sv
